[rtl/offset_to_line_map_defines.svh]
// Assertion macros shared by the offset_to_line_map checker.
// Each macro expects clk and rst in the scope where it is used.
`ifndef OFFSET_TO_LINE_MAP_DEFINES_SVH
`define OFFSET_TO_LINE_MAP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OLM_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OLM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/olm_pkg.sv]
// Shared types and constants for the offset_to_line_map block.
// Used by the controller, the datapath, the top level and the checker.
package olm_pkg;

  localparam int ENTRIES     = 1024;
  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;
  localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS    = $clog2(ENTRIES + 1);

  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [CNT_BITS:0]      cnt_sum_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LINE_BITS-1:0]   line_t;

  localparam offset_t OFFSET_MAX  = '1;
  localparam cnt_t    ENTRIES_CNT = cnt_t'(ENTRIES);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic    op;
    line_t   line_number;
    offset_t code_offset;
  } olm_in_t;

  typedef struct packed {
    line_t      found_line;
    logic [1:0] status;
  } olm_out_t;

  typedef struct packed {
    offset_t start;
    line_t   line;
  } olm_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic start_write;
    logic start_lookup;
    logic step;
    logic load_out;
  } olm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic search_done;
  } olm_stat_t;

endpackage

[rtl/olm_datapath.sv]
// Datapath of offset_to_line_map: entry memory, byte and entry counters,
// binary-search bounds and the output register. Depends on olm_pkg.
module olm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  olm_pkg::olm_in_t  in_data,
  input  olm_pkg::olm_cmd_t cmd,
  output olm_pkg::olm_stat_t stat,
  output olm_pkg::olm_out_t out_data
);

  olm_pkg::olm_entry_t mem [olm_pkg::ENTRIES];
  olm_pkg::olm_entry_t rdata;
  olm_pkg::idx_t       rd_addr;

  olm_pkg::offset_t byte_count;
  olm_pkg::cnt_t    entry_count;
  olm_pkg::line_t   last_line;

  olm_pkg::cnt_t    lo;
  olm_pkg::cnt_t    hi;
  olm_pkg::offset_t key;
  olm_pkg::line_t   best_line;
  logic [1:0]       res_status;

  olm_pkg::cnt_t     mid;
  olm_pkg::cnt_t     lo_next;
  olm_pkg::cnt_t     hi_next;
  olm_pkg::cnt_sum_t sum_cur;
  olm_pkg::cnt_sum_t sum_next;
  logic              le;
  logic              need;
  logic              full;
  logic              sat;

  always_comb begin
    sum_cur  = {1'b0, lo} + {1'b0, hi};
    mid      = olm_pkg::cnt_t'(sum_cur >> 1);
    le       = (rdata.start <= key);
    lo_next  = le ? olm_pkg::cnt_t'(mid + 1'b1) : lo;
    hi_next  = le ? hi : mid;
    sum_next = {1'b0, lo_next} + {1'b0, hi_next};
    // Fetch the next probe so its data is ready for the following step.
    if (cmd.start_lookup) begin
      rd_addr = olm_pkg::idx_t'(entry_count >> 1);
    end else begin
      rd_addr = olm_pkg::idx_t'(sum_next >> 1);
    end
    need = (entry_count == '0) || (last_line != in_data.line_number);
    full = (entry_count == olm_pkg::ENTRIES_CNT);
    sat  = (byte_count == olm_pkg::OFFSET_MAX);
    stat.search_done = (lo >= hi);
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (cmd.start_write && need && !full) begin
      mem[olm_pkg::idx_t'(entry_count)] <= '{start: byte_count, line: in_data.line_number};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      entry_count <= '0;
    end else if (cmd.start_write) begin
      if (need && !full) begin
        entry_count <= entry_count + 1'b1;
      end
      if (!sat) begin
        byte_count <= byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_write) begin
      if (need && !full) begin
        last_line <= in_data.line_number;
      end
      best_line <= '0;
      if (need && full) begin
        res_status <= olm_pkg::ST_FULL;
      end else if (sat) begin
        res_status <= olm_pkg::ST_SAT;
      end else begin
        res_status <= olm_pkg::ST_OK;
      end
    end
    if (cmd.start_lookup) begin
      lo         <= '0;
      hi         <= entry_count;
      key        <= in_data.code_offset;
      best_line  <= '0;
      res_status <= olm_pkg::ST_OK;
    end
    if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
      // The last probe that fits is the predecessor.
      if (le) begin
        best_line <= rdata.line;
      end
    end
    if (cmd.load_out) begin
      out_data <= '{found_line: best_line, status: res_status};
    end
  end

endmodule

[rtl/olm_ctrl.sv]
// Controller of offset_to_line_map: sequences writes and lookups and owns
// the input stall and output valid. Depends on olm_pkg.
module olm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  olm_pkg::olm_stat_t stat,
  output olm_pkg::olm_cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    DONE
  } state_t;

  state_t state;
  logic   out_free;

  always_comb begin
    out_free         = !out_valid || !out_stall;
    in_stall         = (state != IDLE);
    cmd.start_write  = (state == IDLE) && in_valid && (in_op == olm_pkg::OP_WRITE);
    cmd.start_lookup = (state == IDLE) && in_valid && (in_op == olm_pkg::OP_LOOKUP);
    cmd.step         = (state == SEARCH) && !stat.search_done;
    cmd.load_out     = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.start_write) begin
            state <= DONE;
          end else if (cmd.start_lookup) begin
            state <= SEARCH;
          end
        end
        SEARCH: begin
          if (stat.search_done) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/offset_to_line_map.sv]
// Offset-to-line map: a run-length table of (start offset, line) entries.
// A write transaction records one code byte; its result passes through
// the DONE state into the output register. A lookup returns the line of
// the last entry starting at or before the offset (0 if none) after at
// most clog2(entry count + 1) binary-search steps in a table of up to
// 1024 entries. Each step costs one read of the entry memory, which sets
// the lookup latency. One transaction is in flight at a time; the next is
// accepted while the previous result waits in the output register. The
// table needs no clearing after reset.
module offset_to_line_map (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  olm_pkg::olm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output olm_pkg::olm_out_t out_data
);

  olm_pkg::olm_cmd_t  cmd;
  olm_pkg::olm_stat_t stat;

  olm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  olm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

[rtl/olm_checker.sv]
// Port-level checks for offset_to_line_map, bound to the top level.
// Depends on olm_pkg and offset_to_line_map_defines.svh.
`include "offset_to_line_map_defines.svh"

module olm_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input olm_pkg::olm_out_t out_data
);

  logic out_held;
  logic status_known;
  logic flagged_out;
  logic line_zero;

  assign out_held     = out_valid && out_stall;
  assign status_known = (out_data.status == olm_pkg::ST_OK) ||
                        (out_data.status == olm_pkg::ST_FULL) ||
                        (out_data.status == olm_pkg::ST_SAT);
  assign flagged_out  = out_valid && (out_data.status != olm_pkg::ST_OK);
  assign line_zero    = (out_data.found_line == '0);

  `OLM_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled result changed")

  `OLM_ASSERT_SAME(a_status_code, out_valid, status_known, "bad status code")

  `OLM_ASSERT_SAME(a_flag_no_line, flagged_out, line_zero, "flagged write carries a line")

  `OLM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")

endmodule

bind offset_to_line_map olm_checker u_olm_checker (.*);
